// File: rtl/stdc_pkg.sv
// Shared types and constants for the settable time-of-day clock.
// Used by stdc_steps, stdc_core and settable_time_of_day_clock_top.
package stdc_pkg;

  localparam int unsigned RAW_W  = 16;
  localparam int unsigned STEP_W = 12;
  localparam int unsigned HOUR_W = 5;
  localparam int unsigned MIN_W  = 6;

  localparam logic [HOUR_W-1:0] LAST_HOUR = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  LAST_MIN  = MIN_W'(59);

  typedef enum logic [1:0] {
    UNIT_NONE    = 2'd0,
    UNIT_HOURS   = 2'd1,
    UNIT_MINUTES = 2'd2,
    UNIT_SECONDS = 2'd3
  } unit_e;

  // One sample tick, with the encoder count already reduced to steps.
  typedef struct packed {
    logic              left_button;
    logic              right_button;
    logic              mode_switch;
    logic [STEP_W-1:0] encoder_steps;
  } item_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hours_shown;
    logic [MIN_W-1:0]  minutes_shown;
    logic [MIN_W-1:0]  seconds_shown;
    logic              setting_mode;
    unit_e             selected_unit;
    logic [STEP_W-1:0] encoder_steps;
  } result_t;

endpackage

// File: rtl/stdc_steps.sv
// Encoder step count: raw count divided by 18.
// Depends on stdc_pkg for field widths.
module stdc_steps (
  input  logic [stdc_pkg::RAW_W-1:0]  raw_i,
  output logic [stdc_pkg::STEP_W-1:0] steps_o
);
  import stdc_pkg::*;

  // raw / 18 = (raw >> 1) / 9, and x / 9 = (x * ceil(2^18 / 9)) >> 18 for x < 2^15
  localparam logic [RAW_W-2:0] RECIP9 = (RAW_W-1)'(29128);

  logic [RAW_W-2:0]     half;
  logic [2*RAW_W-3:0]   prod;

  assign half    = raw_i[RAW_W-1:1];
  assign prod    = (2*RAW_W-2)'(half) * (2*RAW_W-2)'(RECIP9);
  assign steps_o = prod[2*RAW_W-3 -: STEP_W];

endmodule

// File: rtl/stdc_core.sv
// Clock state and per-tick update: run-mode time keeping, set-mode editing.
// Depends on stdc_pkg for the item and result types.
module stdc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  stdc_pkg::item_t   item_i,
  output stdc_pkg::result_t result_o
);
  import stdc_pkg::*;

  localparam int unsigned MOD_W = 13;
  // Multiple of 120 that lifts any base + delta above zero
  localparam logic [MOD_W-1:0] LIFT     = MOD_W'(3720);
  localparam logic [13:0]      RECIP60  = 14'd8739;
  localparam logic [13:0]      RECIP24  = 14'd10923;
  localparam logic [MOD_W-1:0] DIV60    = MOD_W'(60);
  localparam logic [MOD_W-1:0] DIV24    = MOD_W'(24);

  logic [HOUR_W-1:0] hour_q, hour_d, set_h_q, set_h_d, base_h_q, base_h_d;
  logic [MIN_W-1:0]  min_q, min_d, set_m_q, set_m_d, base_m_q, base_m_d;
  logic [MIN_W-1:0]  sec_q, sec_d, set_s_q, set_s_d, base_s_q, base_s_d;
  logic [STEP_W-1:0] ebase_q, ebase_d;
  logic              mode_q, mode_d;
  unit_e             unit_q, unit_d;
  logic              prev_l_q, prev_r_q, prev_sw_q;

  logic              sw_fall, l_fall, r_fall, latch;
  logic [HOUR_W-1:0] set_h0, base_h_eff;
  logic [MIN_W-1:0]  set_m0, set_s0, base_m_eff, base_s_eff, base_sel;
  logic [STEP_W-1:0] ebase_eff;
  logic [MOD_W-1:0]  lifted;
  logic [26:0]       prod60, prod24;
  logic [MOD_W-1:0]  rem60, rem24;

  assign sw_fall = !item_i.mode_switch && prev_sw_q;
  assign l_fall  = !item_i.left_button && prev_l_q;
  assign r_fall  = !item_i.right_button && prev_r_q;
  assign latch   = l_fall || r_fall;

  // A switch edge clears the set time before the bases are latched
  assign set_h0 = sw_fall ? '0 : set_h_q;
  assign set_m0 = sw_fall ? '0 : set_m_q;
  assign set_s0 = sw_fall ? '0 : set_s_q;

  assign base_h_eff = latch ? set_h0 : base_h_q;
  assign base_m_eff = latch ? set_m0 : base_m_q;
  assign base_s_eff = latch ? set_s0 : base_s_q;
  assign ebase_eff  = latch ? item_i.encoder_steps : ebase_q;

  always_comb begin
    unit_d = unit_q;
    if (l_fall) begin
      if (unit_q != UNIT_SECONDS) unit_d = unit_e'(unit_q + 2'd1);
    end else if (r_fall) begin
      if (unit_q != UNIT_NONE) unit_d = unit_e'(unit_q - 2'd1);
    end
  end

  always_comb begin
    case (unit_d)
      UNIT_HOURS:   base_sel = MIN_W'(base_h_eff);
      UNIT_MINUTES: base_sel = base_m_eff;
      UNIT_SECONDS: base_sel = base_s_eff;
      default:      base_sel = '0;
    endcase
  end

  // Wrapped modulo: lift into positive range, then reciprocal divide
  assign lifted = MOD_W'(base_sel) + MOD_W'(item_i.encoder_steps) - MOD_W'(ebase_eff) + LIFT;
  assign prod60 = 27'(lifted) * 27'(RECIP60);
  assign prod24 = 27'(lifted) * 27'(RECIP24);
  assign rem60  = lifted - MOD_W'(prod60[26:19]) * DIV60;
  assign rem24  = lifted - MOD_W'(prod24[26:18]) * DIV24;

  always_comb begin
    hour_d   = hour_q;
    min_d    = min_q;
    sec_d    = sec_q;
    mode_d   = mode_q;
    set_h_d  = set_h_q;
    set_m_d  = set_m_q;
    set_s_d  = set_s_q;
    base_h_d = base_h_q;
    base_m_d = base_m_q;
    base_s_d = base_s_q;
    ebase_d  = ebase_q;

    result_o.encoder_steps = item_i.encoder_steps;

    if (!mode_q) begin
      result_o.hours_shown   = hour_q;
      result_o.minutes_shown = min_q;
      result_o.seconds_shown = sec_q;
      result_o.selected_unit = unit_q;
      // advance h:m:s with carry, wrap at end of day
      if (sec_q == LAST_MIN) begin
        sec_d = '0;
        if (min_q == LAST_MIN) begin
          min_d  = '0;
          hour_d = (hour_q == LAST_HOUR) ? '0 : hour_q + 1'b1;
        end else begin
          min_d = min_q + 1'b1;
        end
      end else begin
        sec_d = sec_q + 1'b1;
      end
      if (sw_fall) mode_d = 1'b1;
    end else begin
      if (sw_fall) begin
        hour_d = set_h_q;
        min_d  = set_m_q;
        sec_d  = set_s_q;
        mode_d = 1'b0;
      end
      if (latch) begin
        base_h_d = set_h0;
        base_m_d = set_m0;
        base_s_d = set_s0;
        ebase_d  = item_i.encoder_steps;
      end
      set_h_d = set_h0;
      set_m_d = set_m0;
      set_s_d = set_s0;
      case (unit_d)
        UNIT_HOURS:   set_h_d = HOUR_W'(rem24);
        UNIT_MINUTES: set_m_d = MIN_W'(rem60);
        UNIT_SECONDS: set_s_d = MIN_W'(rem60);
        default:      ;
      endcase
      result_o.hours_shown   = set_h_d;
      result_o.minutes_shown = set_m_d;
      result_o.seconds_shown = set_s_d;
      result_o.selected_unit = unit_d;
    end
    result_o.setting_mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      mode_q    <= 1'b0;
      unit_q    <= UNIT_NONE;
      set_h_q   <= '0;
      set_m_q   <= '0;
      set_s_q   <= '0;
      base_h_q  <= '0;
      base_m_q  <= '0;
      base_s_q  <= '0;
      ebase_q   <= '0;
      prev_l_q  <= 1'b0;
      prev_r_q  <= 1'b0;
      prev_sw_q <= 1'b0;
    end else if (step_i) begin
      hour_q    <= hour_d;
      min_q     <= min_d;
      sec_q     <= sec_d;
      mode_q    <= mode_d;
      // button edges in run mode leave the selector alone
      if (mode_q) unit_q <= unit_d;
      set_h_q   <= set_h_d;
      set_m_q   <= set_m_d;
      set_s_q   <= set_s_d;
      base_h_q  <= base_h_d;
      base_m_q  <= base_m_d;
      base_s_q  <= base_s_d;
      ebase_q   <= ebase_d;
      prev_l_q  <= item_i.left_button;
      prev_r_q  <= item_i.right_button;
      prev_sw_q <= item_i.mode_switch;
    end
  end

endmodule

// File: rtl/settable_time_of_day_clock_top.sv
// Top level of the settable time-of-day clock: input and result registers.
// Depends on stdc_pkg, stdc_steps and stdc_core.
//
// Each transfer on the input channel is one sample tick and yields exactly one
// result. A tick passes through an input register (where the encoder count is
// reduced to steps) and moves into the result register once that register is free,
// so a new tick is taken every cycle while results drain; stdc_core updates its
// state as the result register loads. A result waiting on out_ready_i stalls
// the input register, and in_ready_o drops only when both registers are full.
module settable_time_of_day_clock_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        left_button_i,
  input  logic                        right_button_i,
  input  logic                        mode_switch_i,
  input  logic [stdc_pkg::RAW_W-1:0]  encoder_raw_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [stdc_pkg::HOUR_W-1:0] hours_shown_o,
  output logic [stdc_pkg::MIN_W-1:0]  minutes_shown_o,
  output logic [stdc_pkg::MIN_W-1:0]  seconds_shown_o,
  output logic                        setting_mode_o,
  output logic [1:0]                  selected_unit_o,
  output logic [stdc_pkg::STEP_W-1:0] encoder_steps_o
);
  import stdc_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic              out_valid_q, out_valid_d;
  item_t             item_q;
  result_t           result_q, result_d;
  logic [STEP_W-1:0] steps;
  logic              advance, take;

  stdc_steps u_steps (
    .raw_i   (encoder_raw_i),
    .steps_o (steps)
  );

  stdc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .result_o (result_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign take       = in_valid_i && in_ready_o;

  assign in_valid_d  = take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.left_button   <= left_button_i;
      item_q.right_button  <= right_button_i;
      item_q.mode_switch   <= mode_switch_i;
      item_q.encoder_steps <= steps;
    end
    if (advance) result_q <= result_d;
  end

  assign out_valid_o     = out_valid_q;
  assign hours_shown_o   = result_q.hours_shown;
  assign minutes_shown_o = result_q.minutes_shown;
  assign seconds_shown_o = result_q.seconds_shown;
  assign setting_mode_o  = result_q.setting_mode;
  assign selected_unit_o = result_q.selected_unit;
  assign encoder_steps_o = result_q.encoder_steps;

endmodule
